// ===== rtl/core/dhm_pkg.sv =====
// ----------------------------------------------------------------------------
// dhm_pkg: shared types, codes and the hash function of the hash multimap
// Table geometry, action and status codes, slot marks and the start-key mixer.
// ----------------------------------------------------------------------------
package dhm_pkg;

    localparam int TableSize = 1024;
    localparam int SlotW     = $clog2(TableSize);
    localparam int CountW    = 11;
    localparam int KeyW      = 31;
    localparam int ValW      = 32;
    localparam int QDepth    = 2;

    typedef enum logic [2:0] {
        ACT_ADD      = 3'd0,
        ACT_INSERT   = 3'd1,
        ACT_FIND     = 3'd2,
        ACT_CONTAINS = 3'd3,
        ACT_ERASE    = 3'd4,
        ACT_CLEAR    = 3'd5,
        ACT_NOP6     = 3'd6,
        ACT_NOP7     = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_SLOT  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_DELETED = 2'd1,
        MARK_VALID   = 2'd2,
        MARK_RSVD    = 2'd3
    } mark_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_CLEAR, BK_STRIDE, BK_READ, BK_EVAL, BK_ERASE, BK_DONE
    } bk_state_t;

    // classified command word passed from front to back
    typedef struct packed {
        action_t           action;
        logic [KeyW-1:0]   key;
        logic [ValW-1:0]   value;
        logic [9:0]        nth;
        logic [9:0]        slot;
        logic [SlotW-1:0]  start;
        logic [31:0]       pre_stride;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [9:0]        slot_index;
        logic [ValW-1:0]   found_value;
        logic [9:0]        live_count;
        logic [9:0]        deleted_count;
    } res_t;

    function automatic logic [31:0] mix_start(input logic [31:0] xi);
        logic [31:0] x;
        x = xi;
        x = (x + 32'h7ed55d16) + (x << 12);
        x = (x ^ 32'hc761c23c) ^ (x >> 19);
        x = (x + 32'h165667b1) + (x << 5);
        x = (x + 32'hd3a2646c) ^ (x << 9);
        x = (x + 32'hfd7046c5) + (x << 3);
        x = (x ^ 32'hb55a4f09) ^ (x >> 16);
        return x;
    endfunction

endpackage

// ===== rtl/core/dhm_if.sv =====
// ----------------------------------------------------------------------------
// dhm_in_if / dhm_out_if: valid/ready channels of the hash multimap
// One word per handshake; accepted when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dhm_in_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  action;
    logic [dhm_pkg::KeyW-1:0]    key;
    logic signed [31:0]          value;
    logic [9:0]                  nth;
    logic [9:0]                  slot;
    modport source (output valid, action, key, value, nth, slot, input ready);
    modport sink   (input valid, action, key, value, nth, slot, output ready);
endinterface

interface dhm_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [9:0]         slot_index;
    logic signed [31:0] found_value;
    logic [9:0]         live_count;
    logic [9:0]         deleted_count;
    modport source (output valid, status, slot_index, found_value, live_count,
                    deleted_count, input ready);
    modport sink   (input valid, status, slot_index, found_value, live_count,
                    deleted_count, output ready);
endinterface

// ===== rtl/core/dhm_front.sv =====
// ----------------------------------------------------------------------------
// dhm_front: accepts words, hashes the key, queues commands for the back end
// Start hash is registered on entry; a two-entry queue decouples the sides.
// ----------------------------------------------------------------------------
module dhm_front (
    input  logic          clk,
    input  logic          rst_n,
    dhm_in_if.sink        in_ch,
    output dhm_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_pop
);
    dhm_pkg::cmd_t q_reg [dhm_pkg::QDepth];
    logic          wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [31:0]   h;
    logic [31:0]   sx;
    logic          push;

    assign in_ch.ready = (cnt_reg != 2'(dhm_pkg::QDepth));
    assign push        = in_ch.valid && in_ch.ready;
    assign h           = dhm_pkg::mix_start({1'b0, in_ch.key});
    assign sx          = {1'b0, in_ch.key} ^ ({1'b0, in_ch.key} >> 16);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{action:     dhm_pkg::action_t'(in_ch.action),
                                   key:        in_ch.key,
                                   value:      in_ch.value,
                                   nth:        in_ch.nth,
                                   slot:       in_ch.slot,
                                   start:      h[dhm_pkg::SlotW-1:0],
                                   pre_stride: sx};
        end
    end

    assign cmd       = q_reg[rd_ptr_reg];
    assign cmd_valid = (cnt_reg != 2'd0);
endmodule

// ===== rtl/core/dhm_back.sv =====
// ----------------------------------------------------------------------------
// dhm_back: probe sequencer over the key and value memories
// One memory read per probe step; stride hash takes two multiply rounds.
// ----------------------------------------------------------------------------
module dhm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  dhm_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    input  logic [9:0]    occupancy_limit,
    output dhm_pkg::res_t res,
    output logic          res_valid,
    input  logic          res_ready
);
    localparam int SW = dhm_pkg::SlotW;
    localparam int CW = dhm_pkg::CountW;

    // key memory: mark in [32:31], key in [30:0]
    logic [32:0] kmem [dhm_pkg::TableSize];
    logic [31:0] vmem [dhm_pkg::TableSize];
    logic [32:0] krd_reg;
    logic [31:0] vrd_reg;

    dhm_pkg::bk_state_t st_reg, st_next;
    logic [SW-1:0]  j_reg, j_next, pos_reg, pos_next, clr_reg, clr_next;
    logic [SW:0]    steps_reg, steps_next;
    logic [31:0]    sm_reg, sm_next;
    logic           sp_reg, sp_next;
    logic [SW-1:0]  stride_reg, stride_next;
    logic [9:0]     n_reg, n_next;
    logic           have_reg, have_next;
    logic [CW-1:0]  live_reg, live_next, del_reg, del_next;
    dhm_pkg::res_t  res_reg, res_next;
    logic           rv_reg, rv_next;
    logic           init_reg;
    logic           kwe, vwe;
    logic [SW-1:0]  kwa, ra;
    logic [32:0]    kwd;
    logic [31:0]    x1;
    logic [CW-1:0]  used;
    logic           full;
    dhm_pkg::mark_t mk;
    logic           keyhit;

    assign x1   = sm_reg ^ (sm_reg >> 16);
    assign used = live_reg + del_reg;
    assign full = ({1'b0, occupancy_limit} <= used)
                  || (32'(used) >= 32'(dhm_pkg::TableSize));
    assign mk     = dhm_pkg::mark_t'(krd_reg[32:31]);
    assign keyhit = (mk == dhm_pkg::MARK_VALID) && (krd_reg[30:0] == cmd.key);

    always_ff @(posedge clk)
    begin
        if (kwe)
            kmem[kwa] <= kwd;
        if (vwe)
            vmem[kwa] <= cmd.value;
        krd_reg <= kmem[ra];
        vrd_reg <= vmem[ra];
    end

    function automatic dhm_pkg::res_t mk_res(input logic [2:0] s, input logic [SW-1:0] w,
                                             input logic [31:0] f, input logic [CW-1:0] l,
                                             input logic [CW-1:0] d);
        mk_res = '{status: s, slot_index: 10'(w), found_value: f,
                   live_count: l[9:0], deleted_count: d[9:0]};
    endfunction

    always_comb
    begin
        st_next = st_reg; j_next = j_reg; pos_next = pos_reg; clr_next = clr_reg;
        steps_next = steps_reg; sm_next = sm_reg; sp_next = sp_reg;
        stride_next = stride_reg; n_next = n_reg; have_next = have_reg;
        live_next = live_reg; del_next = del_reg; res_next = res_reg;
        rv_next = rv_reg && !res_ready;
        cmd_pop = 1'b0; kwe = 1'b0; vwe = 1'b0; kwa = j_reg; kwd = '0;
        ra = j_reg;
        unique case (st_reg)
            dhm_pkg::BK_IDLE:
            begin
                if (cmd_valid && !rv_next)
                begin
                    j_next = cmd.start; steps_next = '0; n_next = cmd.nth;
                    have_next = 1'b0; sm_next = cmd.pre_stride; sp_next = 1'b0;
                    unique case (cmd.action)
                        dhm_pkg::ACT_ADD, dhm_pkg::ACT_INSERT,
                        dhm_pkg::ACT_FIND, dhm_pkg::ACT_CONTAINS:
                            st_next = dhm_pkg::BK_STRIDE;
                        dhm_pkg::ACT_ERASE:
                        begin
                            j_next = cmd.slot[SW-1:0];
                            st_next = (32'(cmd.slot) >= 32'(dhm_pkg::TableSize))
                                      ? dhm_pkg::BK_DONE : dhm_pkg::BK_ERASE;
                            res_next = mk_res(dhm_pkg::ST_BAD_SLOT, '0, '0,
                                              live_reg, del_reg);
                        end
                        dhm_pkg::ACT_CLEAR:
                        begin
                            clr_next = '0; st_next = dhm_pkg::BK_CLEAR;
                        end
                        default:
                        begin
                            res_next = mk_res(dhm_pkg::ST_OK, '0, '0, live_reg, del_reg);
                            st_next = dhm_pkg::BK_DONE;
                        end
                    endcase
                end
            end
            dhm_pkg::BK_CLEAR:
            begin
                kwe = 1'b1; kwa = clr_reg; kwd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SW'(dhm_pkg::TableSize - 1))
                begin
                    live_next = '0; del_next = '0;
                    res_next = mk_res(dhm_pkg::ST_OK, '0, '0, '0, '0);
                    st_next = dhm_pkg::BK_DONE;
                end
            end
            dhm_pkg::BK_STRIDE:
            begin
                // two multiply rounds, one per cycle; the front already folded
                // the upper half of the key into pre_stride
                if (!sp_reg)
                begin
                    sm_next = sm_reg * 32'hdaaa6a5d; sp_next = 1'b1;
                end
                else
                begin
                    sm_next = x1 * 32'hefe65e63;
                    stride_next = SW'((x1 * 32'hefe65e63) ^ ((x1 * 32'hefe65e63) >> 16))
                                  | SW'(1);
                    if (cmd.action == dhm_pkg::ACT_ADD && full)
                    begin
                        res_next = mk_res(dhm_pkg::ST_FULL, '0, '0, live_reg, del_reg);
                        st_next = dhm_pkg::BK_DONE;
                    end
                    else
                        st_next = dhm_pkg::BK_READ;
                end
            end
            dhm_pkg::BK_READ:
                st_next = dhm_pkg::BK_EVAL;
            dhm_pkg::BK_EVAL:
            begin
                st_next = dhm_pkg::BK_READ;
                j_next = j_reg + stride_reg;
                steps_next = steps_reg + 1'b1;
                unique case (cmd.action)
                    dhm_pkg::ACT_ADD:
                    begin
                        if (mk != dhm_pkg::MARK_VALID)
                        begin
                            kwe = 1'b1; vwe = 1'b1; kwd = {2'(dhm_pkg::MARK_VALID), cmd.key};
                            live_next = live_reg + 1'b1;
                            if (mk == dhm_pkg::MARK_DELETED && del_reg != '0)
                                del_next = del_reg - 1'b1;
                            res_next = mk_res(dhm_pkg::ST_OK, j_reg, '0, live_next, del_next);
                            st_next = dhm_pkg::BK_DONE;
                        end
                    end
                    dhm_pkg::ACT_INSERT:
                    begin
                        if (keyhit && vrd_reg == cmd.value)
                        begin
                            res_next = mk_res(dhm_pkg::ST_PRESENT, j_reg, '0,
                                              live_reg, del_reg);
                            st_next = dhm_pkg::BK_DONE;
                        end
                        else
                        begin
                            if (mk != dhm_pkg::MARK_VALID && !have_reg)
                            begin
                                have_next = 1'b1; pos_next = j_reg;
                            end
                            if (mk == dhm_pkg::MARK_EMPTY)
                                st_next = dhm_pkg::BK_ERASE;
                        end
                    end
                    default:
                    begin
                        if (keyhit && (cmd.action == dhm_pkg::ACT_CONTAINS
                                       ? vrd_reg == cmd.value : n_reg == '0))
                        begin
                            res_next = mk_res(dhm_pkg::ST_OK, j_reg, vrd_reg,
                                              live_reg, del_reg);
                            st_next = dhm_pkg::BK_DONE;
                        end
                        else
                        begin
                            if (keyhit)
                                n_next = n_reg - 1'b1;
                            if (mk == dhm_pkg::MARK_EMPTY)
                            begin
                                res_next = mk_res(dhm_pkg::ST_NOT_FOUND, '0, '0,
                                                  live_reg, del_reg);
                                st_next = dhm_pkg::BK_DONE;
                            end
                        end
                    end
                endcase
                // probe cap reached without a decision
                if (st_next == dhm_pkg::BK_READ
                    && steps_reg == (SW+1)'(dhm_pkg::TableSize - 1))
                begin
                    if (cmd.action == dhm_pkg::ACT_INSERT)
                        st_next = dhm_pkg::BK_ERASE;
                    else
                    begin
                        res_next = mk_res((cmd.action == dhm_pkg::ACT_ADD)
                                          ? dhm_pkg::ST_FULL : dhm_pkg::ST_NOT_FOUND,
                                          '0, '0, live_reg, del_reg);
                        st_next = dhm_pkg::BK_DONE;
                    end
                end
                // commit re-reads the chosen slot first
                if (st_next == dhm_pkg::BK_ERASE)
                begin
                    j_next = have_next ? pos_next : j_reg;
                    sp_next = 1'b0;
                end
                if (st_next == dhm_pkg::BK_READ)
                    ra = j_next;
            end
            dhm_pkg::BK_ERASE:
            begin
                // erase commit, or insert commit at the first free slot
                st_next = dhm_pkg::BK_DONE;
                if (cmd.action == dhm_pkg::ACT_ERASE)
                begin
                    if (st_reg == dhm_pkg::BK_ERASE && sp_reg)
                    begin
                        if (mk == dhm_pkg::MARK_VALID)
                        begin
                            kwe = 1'b1; kwd = {2'(dhm_pkg::MARK_DELETED), 31'd0};
                            live_next = live_reg - 1'b1; del_next = del_reg + 1'b1;
                            res_next = mk_res(dhm_pkg::ST_OK, j_reg, '0, live_next, del_next);
                        end
                    end
                    else
                    begin
                        sp_next = 1'b1; st_next = dhm_pkg::BK_ERASE;
                    end
                end
                else if (!have_reg || full)
                    res_next = mk_res(dhm_pkg::ST_FULL, '0, '0, live_reg, del_reg);
                else
                begin
                    if (!sp_reg)
                    begin
                        sp_next = 1'b1; st_next = dhm_pkg::BK_ERASE;
                    end
                    else
                    begin
                        kwe = 1'b1; vwe = 1'b1; kwd = {2'(dhm_pkg::MARK_VALID), cmd.key};
                        live_next = live_reg + 1'b1;
                        if (mk == dhm_pkg::MARK_DELETED && del_reg != '0)
                            del_next = del_reg - 1'b1;
                        res_next = mk_res(dhm_pkg::ST_OK, j_reg, '0, live_next, del_next);
                    end
                end
                if (st_next == dhm_pkg::BK_ERASE)
                    ra = j_reg;
            end
            dhm_pkg::BK_DONE:
            begin
                rv_next = 1'b1; cmd_pop = 1'b1; st_next = dhm_pkg::BK_IDLE;
            end
            default:
                st_next = dhm_pkg::BK_IDLE;
        endcase
        if (st_reg == dhm_pkg::BK_STRIDE && st_next == dhm_pkg::BK_READ)
            ra = j_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= dhm_pkg::BK_CLEAR;
            clr_reg <= '0; live_reg <= '0; del_reg <= '0; rv_reg <= 1'b0;
            init_reg <= 1'b1;
        end
        else
        begin
            // the sweep after reset ends silently; a clear command answers
            st_reg <= (st_reg == dhm_pkg::BK_CLEAR && init_reg
                       && clr_reg == SW'(dhm_pkg::TableSize - 1))
                      ? dhm_pkg::BK_IDLE : st_next;
            if (st_reg == dhm_pkg::BK_CLEAR && clr_reg == SW'(dhm_pkg::TableSize - 1))
                init_reg <= 1'b0;
            clr_reg <= clr_next; live_reg <= live_next; del_reg <= del_next;
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next; pos_reg <= pos_next; steps_reg <= steps_next;
        sm_reg <= sm_next; sp_reg <= sp_next; stride_reg <= stride_next;
        n_reg <= n_next; have_reg <= have_next; res_reg <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = rv_reg;
endmodule

// ===== rtl/core/double_hash_multimap_unit.sv =====
// ----------------------------------------------------------------------------
// double_hash_multimap_unit: 1024-slot open-addressing multimap, double hashed
// Top level: front end, command queue, probe back end and the limit register.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : command words (action, key, value, nth, slot), valid/ready.
//   out_ch : one result word per command (status, slot_index, found_value,
//            live_count, deleted_count), valid/ready.
//   cfg_we / cfg_data write occupancy_limit; write only while idle.
// Timing
//   The front registers the start hash and queues up to two commands.
//   The back first runs the two stride multiply rounds, then steps each
//   probe through a memory read and an evaluate state. Insert and erase
//   add a commit read. Clear sweeps the key memory, one slot per cycle.
// Reset
//   After reset the key memory is swept to empty; during the sweep, commands
//   only queue in the front; occupancy_limit returns to 716.
// Stalls
//   A result waits in the output register while out_ch.ready is low; the
//   back does not start the next command until it has been taken, but the
//   front keeps accepting into the queue.
// ----------------------------------------------------------------------------
module double_hash_multimap_unit (
    input  logic       clk,
    input  logic       rst_n,
    dhm_in_if.sink     in_ch,
    dhm_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [9:0] cfg_data
);
    dhm_pkg::cmd_t cmd;
    dhm_pkg::res_t res;
    logic          cmd_valid, cmd_pop, res_valid;
    logic [9:0]    limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 10'd716;
        else if (cfg_we)
            limit_reg <= cfg_data;
    end

    dhm_front u_front (
        .clk, .rst_n, .in_ch, .cmd, .cmd_valid, .cmd_pop
    );

    dhm_back u_back (
        .clk, .rst_n, .cmd, .cmd_valid, .cmd_pop,
        .occupancy_limit(limit_reg), .res, .res_valid, .res_ready(out_ch.ready)
    );

    assign out_ch.valid         = res_valid;
    assign out_ch.status        = res.status;
    assign out_ch.slot_index    = res.slot_index;
    assign out_ch.found_value   = res.found_value;
    assign out_ch.live_count    = res.live_count;
    assign out_ch.deleted_count = res.deleted_count;
endmodule

// ===== rtl/core/dhm_checker.sv =====
// ----------------------------------------------------------------------------
// dhm_checker: port-level checks of the hash multimap
// ----------------------------------------------------------------------------
module dhm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [9:0] slot_index,
    input logic [31:0] found_value
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped under stall");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'd4)
        else $error("bad status");
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 3'd0 |-> found_value == 32'd0)
        else $error("value on failure");
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == 3'd1 || status == 3'd3 || status == 3'd4)
        |-> slot_index == 10'd0)
        else $error("slot on failure");
endmodule

bind double_hash_multimap_unit dhm_checker u_dhm_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(out_ch.status), .slot_index(out_ch.slot_index),
    .found_value(out_ch.found_value)
);
